### design/cvdf_pkg.sv
// shared types, register indexes and mixing weights for the color vision deficiency filter
package cvdf_pkg;

    // channel width default, range 8 to 24
    localparam int unsigned CHANNEL_BITS_DEF = 16;

    // weight and blend formats
    localparam int unsigned WEIGHT_BITS  = 16;
    localparam int unsigned WEIGHT_SHIFT = 15;
    localparam int unsigned BLEND_BITS   = 9;
    localparam int unsigned BLEND_SHIFT  = 8;
    localparam logic [BLEND_BITS-1:0] BLEND_FULL = 9'd256;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam int unsigned CFG_DATA_BITS  = BLEND_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_MODE   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_AMOUNT = 1'b1;

    // color modes, codes 5 to 7 act as pass-through
    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_DEUTAN = 3'd1,
        MODE_PROTAN = 3'd2,
        MODE_TRITAN = 3'd3,
        MODE_GRAY   = 3'd4
    } mode_t;

    // 3x3 Q1.15 weights, entry index is out_channel*3 + in_channel
    typedef logic [8:0][WEIGHT_BITS-1:0] weights_t;

    function automatic weights_t mode_weights(input logic [2:0] mode);
        weights_t w;
        w = '0;
        case (mode)
            MODE_DEUTAN:
            begin
                w[0] = 16'd20480; w[1] = 16'd12288;
                w[3] = 16'd22938; w[4] = 16'd9830;
                w[8] = 16'd32768;
            end
            MODE_PROTAN:
            begin
                w[0] = 16'd18579; w[1] = 16'd14189;
                w[3] = 16'd18285; w[4] = 16'd14483;
                w[8] = 16'd32768;
            end
            MODE_TRITAN:
            begin
                w[0] = 16'd31130; w[1] = 16'd1638;
                w[4] = 16'd14189; w[5] = 16'd18579;
                w[7] = 16'd15565; w[8] = 16'd17203;
            end
            MODE_GRAY:
            begin
                w[0] = 16'd9798; w[1] = 16'd19235; w[2] = 16'd3735;
                w[3] = 16'd9798; w[4] = 16'd19235; w[5] = 16'd3735;
                w[6] = 16'd9798; w[7] = 16'd19235; w[8] = 16'd3735;
            end
            default:
            begin
                // pass-through: identity matrix, exact after the shift
                w[0] = 16'd32768; w[4] = 16'd32768; w[8] = 16'd32768;
            end
        endcase
        return w;
    endfunction

endpackage

### design/color_vision_deficiency_filter_top.sv
// top level of the color vision deficiency filter: config registers and the five-stage pipeline
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    red_in, green_in, blue_in
//  output    out        out_valid / out_stall  red_out, green_out, blue_out
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel per clock unless in_stall is high; a pixel taken at the input passes through
// the stages weight select, nine products, row sums, blend terms and blend sum, in that order,
// and is registered after each stage before it shows on the outputs with out_valid
// rst_n clears all valid bits and sets mode none and full blend; cfg_ready is always high
// each stage holds its pixel while the one after it is full and stalled; in_stall rises
// only when all five stages hold pixels and out_stall is high
module color_vision_deficiency_filter_top #(
    parameter int unsigned CHANNEL_BITS = cvdf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [CHANNEL_BITS-1:0]              red_in,
    input  logic [CHANNEL_BITS-1:0]              green_in,
    input  logic [CHANNEL_BITS-1:0]              blue_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [CHANNEL_BITS-1:0]              red_out,
    output logic [CHANNEL_BITS-1:0]              green_out,
    output logic [CHANNEL_BITS-1:0]              blue_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cvdf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cvdf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import cvdf_pkg::*;

    logic [2:0]                   color_mode_reg;
    logic [BLEND_BITS-1:0]        blend_amount_reg;

    logic                         in_ready;
    logic                         mid_valid;
    logic                         mid_ready;
    logic [2:0][CHANNEL_BITS-1:0] pix_in;
    logic [2:0][CHANNEL_BITS-1:0] mid_orig;
    logic [2:0][CHANNEL_BITS-1:0] mid_mixed;
    logic [2:0][CHANNEL_BITS-1:0] pix_out;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= MODE_NONE;
            blend_amount_reg <= BLEND_FULL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLOR_MODE:   color_mode_reg   <= cfg_data[2:0];
                REG_BLEND_AMOUNT: blend_amount_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign pix_in   = {blue_in, green_in, red_in};
    assign in_stall = !in_ready;

    // matrix mix
    cvdf_mix #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pix_in    (pix_in),
        .mode      (color_mode_reg),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .orig_out  (mid_orig),
        .mixed_out (mid_mixed)
    );

    // blend with the original
    cvdf_blend #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .orig_in      (mid_orig),
        .mixed_in     (mid_mixed),
        .blend_amount (blend_amount_reg),
        .out_valid    (out_valid),
        .out_ready    (!out_stall),
        .pix_out      (pix_out)
    );

    assign red_out   = pix_out[0];
    assign green_out = pix_out[1];
    assign blue_out  = pix_out[2];

    // input stalls only when the whole pipe is full and the output is stalled
    a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output");

    // an empty output stage frees the whole pipe
    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with output stage empty");

    // a mixer output stalled by the blend stage keeps holding its pixel
    a_mid_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && !mid_ready) |=> mid_valid)
        else $error("mixer output dropped while stalled");

endmodule

### design/cvdf_mix.sv
// three-stage matrix mixer: weight select, products, row sums
module cvdf_mix #(
    parameter int unsigned CHANNEL_BITS = cvdf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0][CHANNEL_BITS-1:0]       pix_in,
    input  logic [2:0]                         mode,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0][CHANNEL_BITS-1:0]       orig_out,
    output logic [2:0][CHANNEL_BITS-1:0]       mixed_out
);
    import cvdf_pkg::*;

    localparam int unsigned PW = CHANNEL_BITS + WEIGHT_SHIFT;
    localparam int unsigned SW = PW + 2;

    // stage 1: pixel and selected weights
    logic                          v1_reg;
    logic [2:0][CHANNEL_BITS-1:0]  pix1_reg;
    weights_t                      w1_reg;
    // stage 2: nine products
    logic                          v2_reg;
    logic [2:0][CHANNEL_BITS-1:0]  pix2_reg;
    logic [8:0][PW-1:0]            prod2_reg;
    logic [8:0][PW-1:0]            prod2_next;
    // stage 3: mixed channels
    logic                          v3_reg;
    logic [2:0][CHANNEL_BITS-1:0]  pix3_reg;
    logic [2:0][CHANNEL_BITS-1:0]  mix3_reg;
    logic [2:0][CHANNEL_BITS-1:0]  mix3_next;

    logic ready1;
    logic ready2;
    logic ready3;

    // a stage takes new data when empty or when the next one moves
    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // weight times channel products
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod2_next[c*3+k] = PW'(pix1_reg[k]) * PW'(w1_reg[c*3+k]);
            end
        end
    end

    // row sums, truncated by the weight shift
    always_comb
    begin
        logic [SW-1:0] acc;
        for (int c = 0; c < 3; c++)
        begin
            acc = SW'(prod2_reg[c*3]) + SW'(prod2_reg[c*3+1]) + SW'(prod2_reg[c*3+2]);
            mix3_next[c] = acc[WEIGHT_SHIFT +: CHANNEL_BITS];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            pix1_reg <= pix_in;
            w1_reg   <= mode_weights(mode);
        end
        if (ready2 && v1_reg)
        begin
            pix2_reg  <= pix1_reg;
            prod2_reg <= prod2_next;
        end
        if (ready3 && v2_reg)
        begin
            pix3_reg <= pix2_reg;
            mix3_reg <= mix3_next;
        end
    end

    assign out_valid = v3_reg;
    assign orig_out  = pix3_reg;
    assign mixed_out = mix3_reg;

endmodule

### design/cvdf_blend.sv
// two-stage blend of mixed and original pixel, ends in the output register
module cvdf_blend #(
    parameter int unsigned CHANNEL_BITS = cvdf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0][CHANNEL_BITS-1:0]        orig_in,
    input  logic [2:0][CHANNEL_BITS-1:0]        mixed_in,
    input  logic [cvdf_pkg::BLEND_BITS-1:0]     blend_amount,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0][CHANNEL_BITS-1:0]        pix_out
);
    import cvdf_pkg::*;

    localparam int unsigned BW = CHANNEL_BITS + BLEND_BITS;
    localparam int unsigned AW = BW + 1;

    logic [BLEND_BITS-1:0]        b_sat;
    logic [BLEND_BITS-1:0]        b_inv;

    // stage 4: weighted terms
    logic                         v4_reg;
    logic [2:0][BW-1:0]           lo4_reg;
    logic [2:0][BW-1:0]           hi4_reg;
    logic [2:0][BW-1:0]           lo4_next;
    logic [2:0][BW-1:0]           hi4_next;
    // stage 5: output register
    logic                         v5_reg;
    logic [2:0][CHANNEL_BITS-1:0] pix5_reg;
    logic [2:0][CHANNEL_BITS-1:0] pix5_next;

    logic ready4;
    logic ready5;

    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign in_ready = ready4;

    // blend weight saturates at full effect
    assign b_sat = (blend_amount > BLEND_FULL) ? BLEND_FULL : blend_amount;
    assign b_inv = BLEND_FULL - b_sat;

    // original and mixed terms
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lo4_next[c] = BW'(orig_in[c]) * BW'(b_inv);
            hi4_next[c] = BW'(mixed_in[c]) * BW'(b_sat);
        end
    end

    // sum and drop the blend fraction
    always_comb
    begin
        logic [AW-1:0] acc;
        for (int c = 0; c < 3; c++)
        begin
            acc = AW'(lo4_reg[c]) + AW'(hi4_reg[c]);
            pix5_next[c] = acc[BLEND_SHIFT +: CHANNEL_BITS];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
            begin
                v4_reg <= in_valid;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (ready4 && in_valid)
        begin
            lo4_reg <= lo4_next;
            hi4_reg <= hi4_next;
        end
        if (ready5 && v4_reg)
        begin
            pix5_reg <= pix5_next;
        end
    end

    assign out_valid = v5_reg;
    assign pix_out   = pix5_reg;

endmodule
